@@ rtl/bfs_pkg.sv @@
// Shared types and constants for the bounded FIFO with statistics.
`default_nettype none
package bfs_pkg;

  localparam int unsigned ValW      = 32;
  localparam int unsigned CntW      = 64;
  localparam int unsigned CfgW      = 5;
  localparam int unsigned OccW      = 5;
  localparam int unsigned DefDepth  = 16;
  localparam logic [CfgW-1:0] CfgReset = 5'd16;

  typedef enum logic {
    CmdAdd = 1'b0,
    CmdGet = 1'b1
  } cmd_e;

  // per-beat control broadcast to every cell
  typedef struct packed {
    logic add;
    logic get;
  } cell_ctl_t;

  // per-beat events for the statistics counters
  typedef struct packed {
    logic add_try;
    logic get_try;
    logic add_ok;
    logic get_ok;
  } stat_ev_t;

endpackage
`default_nettype wire

@@ rtl/bfs_cell.sv @@
// One storage cell of the shifting queue: holds a value and its valid bit.
`default_nettype none
module bfs_cell
  import bfs_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire cell_ctl_t       ctl_i,
  input  wire logic [ValW-1:0] value_i,
  input  wire logic            prev_valid_i,
  input  wire logic            next_valid_i,
  input  wire logic [ValW-1:0] next_data_i,
  output logic                 valid_o,
  output logic [ValW-1:0]      data_o
);

  logic            valid_q, valid_d;
  logic [ValW-1:0] data_q, data_d;
  logic            take;

  // first empty cell of the row catches the new value
  assign take = ctl_i.add && !valid_q && prev_valid_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (ctl_i.get) begin
      valid_d = next_valid_i;
      data_d  = next_data_i;
    end else if (take) begin
      valid_d = 1'b1;
      data_d  = value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

@@ rtl/bfs_stats.sv @@
// Four wrapping 64-bit event counters.
`default_nettype none
module bfs_stats
  import bfs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire stat_ev_t    ev_i,
  output logic [CntW-1:0]  add_tries_o,
  output logic [CntW-1:0]  get_tries_o,
  output logic [CntW-1:0]  adds_done_o,
  output logic [CntW-1:0]  gets_done_o
);

  logic [CntW-1:0] add_try_q, get_try_q, add_ok_q, get_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      add_try_q <= '0;
      get_try_q <= '0;
      add_ok_q  <= '0;
      get_ok_q  <= '0;
    end else begin
      if (ev_i.add_try) add_try_q <= add_try_q + CntW'(1);
      if (ev_i.get_try) get_try_q <= get_try_q + CntW'(1);
      if (ev_i.add_ok)  add_ok_q  <= add_ok_q + CntW'(1);
      if (ev_i.get_ok)  get_ok_q  <= get_ok_q + CntW'(1);
    end
  end

  assign add_tries_o = add_try_q;
  assign get_tries_o = get_try_q;
  assign adds_done_o = add_ok_q;
  assign gets_done_o = get_ok_q;

endmodule
`default_nettype wire

@@ rtl/bounded_fifo_with_stats.sv @@
// Top level of the bounded FIFO with statistics: cell row, fill count, counters.
// Bounded FIFO of signed 32-bit values built as a row of DEPTH cells; cell 0
// always holds the oldest value. An add drops the value into the first empty
// cell, a get hands every cell's content one place toward cell 0. Each input
// beat (add or get) yields exactly one result beat in the next cycle, carrying
// ok, the dequeued value (zero unless a get succeeded), the occupancy after the
// operation and four wrapping 64-bit counters. One beat is taken per clock:
// the result sits in an output register and a new beat is accepted whenever
// that register is empty or being drained in the same cycle, so throughput is
// limited only by the consumer. max_entries (reset 16) caps the occupancy; a
// value above DEPTH acts as DEPTH, and lowering it below the current occupancy
// only blocks adds. Write it only while the block is idle. No clearing pass
// after reset: stored values need no initialization.
`default_nettype none
module bounded_fifo_with_stats
  import bfs_pkg::*;
#(
  parameter int unsigned DEPTH = DefDepth
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [CfgW-1:0] cfg_wdata_i,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic            cmd_i,
  input  wire logic [ValW-1:0] value_in_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic                 ok_o,
  output logic [ValW-1:0]      value_out_o,
  output logic [OccW-1:0]      occupancy_o,
  output logic [CntW-1:0]      add_tries_o,
  output logic [CntW-1:0]      get_tries_o,
  output logic [CntW-1:0]      adds_done_o,
  output logic [CntW-1:0]      gets_done_o
);

  logic [CfgW-1:0] max_q;
  logic [CfgW-1:0] limit;
  logic [OccW-1:0] fill_q, fill_d;
  logic            out_valid_q;
  logic            ok_q, ok_d;
  logic [ValW-1:0] vout_q, vout_d;
  logic            in_fire, is_get, add_ok, get_ok;
  cell_ctl_t       ctl;
  stat_ev_t        ev;

  logic [DEPTH:0]  cell_valid;
  logic [ValW-1:0] cell_data [DEPTH+1];

  assign limit = (32'(max_q) > 32'(DEPTH)) ? CfgW'(DEPTH) : max_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_get     = (cmd_i == CmdGet);
  assign add_ok     = in_fire && !is_get && (32'(fill_q) < 32'(limit));
  assign get_ok     = in_fire && is_get && (fill_q != '0);

  assign ctl.add = add_ok;
  assign ctl.get = get_ok;

  assign ev.add_try = in_fire && !is_get;
  assign ev.get_try = in_fire && is_get;
  assign ev.add_ok  = add_ok;
  assign ev.get_ok  = get_ok;

  // sentinel past the last cell: empty
  assign cell_valid[DEPTH] = 1'b0;
  assign cell_data[DEPTH]  = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic prev_valid;
    if (i == 0) begin : g_first
      assign prev_valid = 1'b1;
    end else begin : g_rest
      assign prev_valid = cell_valid[i-1];
    end

    bfs_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .value_i      (value_in_i),
      .prev_valid_i (prev_valid),
      .next_valid_i (cell_valid[i+1]),
      .next_data_i  (cell_data[i+1]),
      .valid_o      (cell_valid[i]),
      .data_o       (cell_data[i])
    );
  end

  bfs_stats u_stats (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ev_i        (ev),
    .add_tries_o (add_tries_o),
    .get_tries_o (get_tries_o),
    .adds_done_o (adds_done_o),
    .gets_done_o (gets_done_o)
  );

  always_comb begin
    fill_d = fill_q;
    if (add_ok) begin
      fill_d = fill_q + OccW'(1);
    end else if (get_ok) begin
      fill_d = fill_q - OccW'(1);
    end
    ok_d   = add_ok || get_ok;
    vout_d = get_ok ? cell_data[0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q       <= CfgReset;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) max_q <= cfg_wdata_i;
      fill_q <= fill_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ok_q   <= ok_d;
      vout_q <= vout_d;
    end
  end

  // counters and fill only move on an accepted beat, which also reloads the
  // output register, so they can be shown directly
  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;
  assign value_out_o = vout_q;
  assign occupancy_o = fill_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= 32'(DEPTH))
    else $error("fill count exceeds depth");

  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_valid[0] == (fill_q != '0))
    else $error("head cell valid disagrees with fill count");

  a_fill_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    OccW'(adds_done_o[OccW-1:0] - gets_done_o[OccW-1:0]) == fill_q)
    else $error("success counters disagree with fill count");

  a_empty_get: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && is_get && fill_q == '0) |=> (!ok_q && vout_q == '0))
    else $error("get on empty queue reported success");

endmodule
`default_nettype wire

@@ bench/tb.sv @@
// Self-checking bench for the bounded FIFO with statistics: random traffic, scoreboard.
module tb;
  import bfs_pkg::*;

  localparam int StallLimit = 2000;
  localparam int LongHold   = 150;

  typedef struct {
    cmd_e            cmd;
    logic [ValW-1:0] value;
  } fifo_op_t;

  typedef struct packed {
    logic            ok;
    logic [ValW-1:0] value;
    logic [OccW-1:0] occ;
    logic [CntW-1:0] add_try;
    logic [CntW-1:0] get_try;
    logic [CntW-1:0] add_ok;
    logic [CntW-1:0] get_ok;
  } fifo_status_t;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            cfg_we_i    = 1'b0;
  logic [CfgW-1:0] cfg_wdata_i = '0;
  logic            in_valid_i  = 1'b0;
  logic            cmd_i       = 1'b0;
  logic [ValW-1:0] value_in_i  = '0;
  logic            out_ready_i = 1'b0;
  logic            in_ready_o;
  logic            out_valid_o;
  logic            ok_o;
  logic [ValW-1:0] value_out_o;
  logic [OccW-1:0] occupancy_o;
  logic [CntW-1:0] add_tries_o;
  logic [CntW-1:0] get_tries_o;
  logic [CntW-1:0] adds_done_o;
  logic [CntW-1:0] gets_done_o;

  bounded_fifo_with_stats uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .value_in_i  (value_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ok_o        (ok_o),
    .value_out_o (value_out_o),
    .occupancy_o (occupancy_o),
    .add_tries_o (add_tries_o),
    .get_tries_o (get_tries_o),
    .adds_done_o (adds_done_o),
    .gets_done_o (gets_done_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow queue state
  logic [ValW-1:0] ring [DefDepth];
  int unsigned     rd_ptr = 0;
  int unsigned     wr_ptr = 0;
  int unsigned     level  = 0;
  logic [CntW-1:0] n_add_try = '0;
  logic [CntW-1:0] n_get_try = '0;
  logic [CntW-1:0] n_add_ok  = '0;
  logic [CntW-1:0] n_get_ok  = '0;
  logic [CfgW-1:0] limit_reg = CfgReset;

  fifo_op_t     op_q[$];
  fifo_status_t status_q[$];
  int issued_cnt   = 0;
  int acc_cnt      = 0;
  int done_cnt     = 0;
  int errors       = 0;
  int tx_gap       = 0;
  int tx_smooth    = 0;
  int rx_gap       = 0;
  int rx_smooth    = 0;
  int next_hold    = 400;
  int stall_cycles = 0;

  function automatic fifo_status_t apply_fifo_op(logic c, logic [ValW-1:0] v);
    fifo_status_t s;
    int unsigned  lim;
    s   = '0;
    lim = (limit_reg > DefDepth) ? DefDepth : limit_reg;
    if (c == CmdAdd) begin
      n_add_try++;
      if (level < lim) begin
        ring[wr_ptr] = v;
        wr_ptr = (wr_ptr + 1) % DefDepth;
        level++;
        n_add_ok++;
        s.ok = 1'b1;
      end
    end else begin
      n_get_try++;
      if (level != 0) begin
        s.value = ring[rd_ptr];
        rd_ptr = (rd_ptr + 1) % DefDepth;
        level--;
        n_get_ok++;
        s.ok = 1'b1;
      end
    end
    s.occ     = OccW'(level);
    s.add_try = n_add_try;
    s.get_try = n_get_try;
    s.add_ok  = n_add_ok;
    s.get_ok  = n_get_ok;
    return s;
  endfunction

  // mostly short gaps, a few long ones, now and then a run with none
  function automatic int pick_gap(inout int smooth);
    int r;
    if (smooth > 0) begin
      smooth--;
      return 0;
    end
    r = $urandom_range(99, 0);
    if (r < 2) begin
      smooth = $urandom_range(60, 20);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(50, 20);
  endfunction

  task automatic flag_mismatch(input string what);
    $display("mismatch at beat %0d: %s", done_cnt, what);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [CntW-1:0] got,
                             input logic [CntW-1:0] want);
    if (got !== want)
      flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic push_op(input cmd_e c, input logic [ValW-1:0] v);
    fifo_op_t op;
    op.cmd   = c;
    op.value = v;
    op_q.push_back(op);
    issued_cnt++;
  endtask

  task automatic wait_idle();
    while (done_cnt != issued_cnt) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [CfgW-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    limit_reg = v;
  endtask

  function automatic logic [ValW-1:0] pick_value();
    case ($urandom_range(9, 0))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h00000000;
      3: return 32'hffffffff;
      default: return $urandom;
    endcase
  endfunction

  // input driver
  always @(posedge clk_i) begin : drv
    fifo_op_t nxt;
    logic     drive_v;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      drive_v = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        status_q.push_back(apply_fifo_op(cmd_i, value_in_i));
        acc_cnt++;
        tx_gap  = pick_gap(tx_smooth);
        drive_v = 1'b0;
      end
      if (!drive_v) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (op_q.size() != 0) begin
          nxt = op_q.pop_front();
          cmd_i      <= nxt.cmd;
          value_in_i <= nxt.value;
          drive_v = 1'b1;
        end
      end
      in_valid_i <= drive_v;
    end
  end

  // result side backpressure, with a long hold-off now and then
  always @(posedge clk_i) begin : rx
    logic rdy;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) rx_gap = pick_gap(rx_smooth);
      if (acc_cnt >= next_hold) begin
        rx_gap = LongHold;
        next_hold += 800;
      end
      if (rx_gap > 0) begin
        rx_gap--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_ready_i <= rdy;
    end
  end

  // result checker
  always @(posedge clk_i) begin : mon
    fifo_status_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (status_q.size() == 0) begin
        flag_mismatch("result beat with nothing outstanding");
      end else begin
        want = status_q.pop_front();
        check_field("ok", CntW'(ok_o), CntW'(want.ok));
        check_field("value_out", CntW'(value_out_o), CntW'(want.value));
        check_field("occupancy", CntW'(occupancy_o), CntW'(want.occ));
        check_field("add_tries", add_tries_o, want.add_try);
        check_field("get_tries", get_tries_o, want.get_try);
        check_field("adds_done", adds_done_o, want.add_ok);
        check_field("gets_done", gets_done_o, want.get_ok);
        done_cnt++;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  int phase_limit [10] = '{31, 3, 16, 1, 0, 17, 8, 16, 5, 16};
  int phase_add   [10] = '{75, 40, 70, 50, 50, 60, 45, 55, 65, 50};

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset limit: get on empty, extreme values through and back out
    push_op(CmdGet, 32'h00000000);
    push_op(CmdAdd, 32'h7fffffff);
    push_op(CmdAdd, 32'h80000000);
    push_op(CmdAdd, 32'h00000000);
    push_op(CmdAdd, 32'hffffffff);
    repeat (4) push_op(CmdGet, 32'hffffffff);
    push_op(CmdGet, 32'h12345678);
    wait_idle();

    // zero limit refuses every add
    write_limit(5'd0);
    push_op(CmdAdd, 32'h55aa55aa);
    push_op(CmdGet, 32'h00000000);
    wait_idle();

    // fill to a limit of two, third add refused
    write_limit(5'd2);
    push_op(CmdAdd, 32'haaaa5555);
    push_op(CmdAdd, 32'h00000001);
    push_op(CmdAdd, 32'hdeadbeef);
    wait_idle();

    // limit dropped under occupancy: adds blocked until gets drain below it
    write_limit(5'd1);
    push_op(CmdAdd, 32'h0badf00d);
    push_op(CmdGet, 32'h00000000);
    push_op(CmdAdd, 32'hcafef00d);
    push_op(CmdGet, 32'h00000000);
    push_op(CmdAdd, 32'hfeedface);
    push_op(CmdGet, 32'h00000000);
    wait_idle();

    foreach (phase_limit[p]) begin
      write_limit(CfgW'(phase_limit[p]));
      repeat (155) begin
        if ($urandom_range(99, 0) < phase_add[p]) push_op(CmdAdd, pick_value());
        else push_op(CmdGet, pick_value());
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
